[sv/bcdsa_pkg.sv]
package bcdsa_pkg;

  localparam int NDIGITS    = 16;
  localparam int NSLOTS     = 16;
  localparam int AMT_W      = 32;
  localparam int CNT_W      = 5;
  localparam int IDX_W      = 4;
  localparam int FIFO_DEPTH = 2;

  localparam logic [3:0]       RADIX     = 4'd10;
  localparam logic [3:0]       DIGIT_MAX = 4'd9;
  localparam logic [AMT_W-1:0] RECIP10   = 32'hCCCC_CCCD;
  localparam int               RECIP_SH  = 35;

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [AMT_W-1:0] mag;
  } cmd_t;

endpackage

[sv/bcdsa_front.sv]
module bcdsa_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic signed [bcdsa_pkg::AMT_W-1:0] amount_i,
  output logic                             cmd_valid_o,
  output bcdsa_pkg::cmd_t                  cmd_o,
  input  logic                             cmd_pop_i
);
  import bcdsa_pkg::*;

  cmd_t       mem_q [FIFO_DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_in;
  logic       do_push, do_pop;

  always_comb begin
    cmd_in.op  = amount_i[AMT_W-1] ? OP_SUB : OP_ADD;
    cmd_in.mag = amount_i[AMT_W-1] ? (~amount_i + 32'd1) : amount_i;
  end

  assign full        = (cnt_q == 2'(FIFO_DEPTH));
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[sv/bcdsa_back.sv]
module bcdsa_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cmd_valid_i,
  input  bcdsa_pkg::cmd_t                      cmd_i,
  output logic                                 cmd_pop_o,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [4*bcdsa_pkg::NSLOTS-1:0]       score_digits_o,
  output logic [bcdsa_pkg::CNT_W-1:0]          digits_in_use_o,
  output logic                                 underflowed_o,
  output logic                                 overflowed_o
);
  import bcdsa_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                state_q, state_d;
  op_e                   op_q, op_d;
  logic [AMT_W-1:0]      mag_q, mag_d;
  logic                  carry_q, carry_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [4*NSLOTS-1:0]   digits_q, digits_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  under_q, under_d;
  logic                  over_q, over_d;
  logic                  res_valid_q, res_valid_d;
  logic [4*NSLOTS-1:0]   res_digits_q, res_digits_d;
  logic [CNT_W-1:0]      res_count_q, res_count_d;
  logic                  res_under_q, res_under_d;
  logic                  res_over_q, res_over_d;

  logic [2*AMT_W-1:0]    prod;
  logic [AMT_W-1:0]      quot, rem_full;
  logic [3:0]            rem, cur;
  logic [4:0]            sum, need, diff;
  logic                  neg, at_top, busy, res_free;
  logic [4*NSLOTS-1:0]   nines;

  assign prod     = 64'(mag_q) * 64'(RECIP10);
  assign quot     = 32'(prod >> RECIP_SH);
  assign rem_full = mag_q - ((quot << 3) + (quot << 1));
  assign rem      = rem_full[3:0];
  assign cur      = digits_q[idx_q[IDX_W-1:0]*4 +: 4];
  assign sum      = 5'(cur) + 5'(rem) + 5'(carry_q);
  assign need     = 5'(rem) + 5'(carry_q);
  assign neg      = (5'(cur) < need);
  assign diff     = neg ? (5'(cur) + 5'(RADIX) - need) : (5'(cur) - need);
  assign at_top   = (idx_q == count_q);
  assign busy     = (mag_q != '0) || carry_q;
  assign res_free = !res_valid_q || pop;

  always_comb begin
    for (int k = 0; k < NSLOTS; k++) begin
      nines[k*4 +: 4] = (k < NDIGITS) ? DIGIT_MAX : 4'd0;
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    mag_d        = mag_q;
    carry_d      = carry_q;
    idx_d        = idx_q;
    digits_d     = digits_q;
    count_d      = count_q;
    under_d      = under_q;
    over_d       = over_q;
    res_valid_d  = res_valid_q && !pop;
    res_digits_d = res_digits_q;
    res_count_d  = res_count_q;
    res_under_d  = res_under_q;
    res_over_d   = res_over_q;
    cmd_pop_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          mag_d     = cmd_i.mag;
          carry_d   = 1'b0;
          idx_d     = '0;
          under_d   = 1'b0;
          over_d    = 1'b0;
          state_d   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!busy) begin
          if (res_free) begin
            res_valid_d  = 1'b1;
            res_digits_d = digits_q;
            res_count_d  = count_q;
            res_under_d  = under_q;
            res_over_d   = over_q;
            state_d      = ST_IDLE;
          end
        end else if (op_q == OP_ADD) begin
          if (at_top && (count_q >= CNT_W'(NDIGITS))) begin
            // saturate at all nines
            digits_d = nines;
            count_d  = CNT_W'(NDIGITS);
            over_d   = 1'b1;
            mag_d    = '0;
            carry_d  = 1'b0;
          end else begin
            if (at_top) count_d = count_q + 5'd1;
            digits_d[idx_q[IDX_W-1:0]*4 +: 4] = (sum > 5'(DIGIT_MAX)) ?
                                                  4'(sum - 5'(RADIX)) : sum[3:0];
            carry_d = (sum > 5'(DIGIT_MAX));
            mag_d   = quot;
            idx_d   = idx_q + 5'd1;
          end
        end else begin
          if (at_top || (neg && (idx_q + 5'd1 == count_q))) begin
            // went below zero
            digits_d = '0;
            count_d  = 5'd1;
            under_d  = 1'b1;
            mag_d    = '0;
            carry_d  = 1'b0;
          end else begin
            digits_d[idx_q[IDX_W-1:0]*4 +: 4] = diff[3:0];
            carry_d = neg;
            mag_d   = quot;
            idx_d   = idx_q + 5'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_ADD;
      mag_q        <= '0;
      carry_q      <= 1'b0;
      idx_q        <= '0;
      digits_q     <= '0;
      count_q      <= 5'd1;
      under_q      <= 1'b0;
      over_q       <= 1'b0;
      res_valid_q  <= 1'b0;
      res_digits_q <= '0;
      res_count_q  <= 5'd1;
      res_under_q  <= 1'b0;
      res_over_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      mag_q        <= mag_d;
      carry_q      <= carry_d;
      idx_q        <= idx_d;
      digits_q     <= digits_d;
      count_q      <= count_d;
      under_q      <= under_d;
      over_q       <= over_d;
      res_valid_q  <= res_valid_d;
      res_digits_q <= res_digits_d;
      res_count_q  <= res_count_d;
      res_under_q  <= res_under_d;
      res_over_q   <= res_over_d;
    end
  end

  assign empty           = !res_valid_q;
  assign score_digits_o  = res_digits_q;
  assign digits_in_use_o = res_count_q;
  assign underflowed_o   = res_under_q;
  assign overflowed_o    = res_over_q;

endmodule

[sv/bcd_score_accumulator_unit.sv]
// The digit engine walks the score digit by digit with a single-digit BCD add/subtract
//   step; a finished result waits in the engine until the result register is free.
// A 2-entry command queue lets new transactions enter while the digit engine works.
// Reset (async, active low): score is a single zero digit, queues empty.
module bcd_score_accumulator_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [bcdsa_pkg::AMT_W-1:0]   amount_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [4*bcdsa_pkg::NSLOTS-1:0]       score_digits_o,
  output logic [bcdsa_pkg::CNT_W-1:0]          digits_in_use_o,
  output logic                                 underflowed_o,
  output logic                                 overflowed_o
);
  import bcdsa_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  bcdsa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .amount_i    (amount_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  bcdsa_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .empty           (empty),
    .pop             (pop),
    .score_digits_o  (score_digits_o),
    .digits_in_use_o (digits_in_use_o),
    .underflowed_o   (underflowed_o),
    .overflowed_o    (overflowed_o)
  );

endmodule
